>>> rtl/obpls_pkg.sv
// shared types and codes of the order book price level store
// used by obpls_front, obpls_back and order_book_price_level_store

package obpls_pkg;

	// operation codes
	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// field widths fixed by the interface
	localparam int PRICE_W = 8;
	localparam int ID_W    = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// one input transaction
	typedef struct packed {
		logic               mode;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [ID_W-1:0]    order_id;
	} item_t;

	// one result transaction
	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] level_count;
	} result_t;

	// classified command between front and back
	typedef struct packed {
		logic               mode;
		logic               side;
		logic               in_range;
		logic [PRICE_W-1:0] price;
		logic [ID_W-1:0]    order_id;
	} cmd_t;

	// command queue handshake, front to back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_link_t;

endpackage

>>> rtl/obpls_front.sv
// front part: accepts items, classifies them and queues them for the back part
// depends on obpls_pkg

module obpls_front #(
	parameter int PRICE_LEVELS = 256,
	parameter int ID_BITS      = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  obpls_pkg::item_t      item,
	input  logic                  hold,
	output logic                  full,
	output obpls_pkg::cmd_link_t  link,
	input  logic                  take
);
	import obpls_pkg::*;

	localparam logic [ID_W-1:0] ID_MASK =
		(ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 64'd1);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       take_ok;
	cmd_t       cmd_new;

	// classify: range check on price, id cut to its stored width
	always_comb begin
		cmd_new.mode     = item.mode;
		cmd_new.side     = item.side;
		cmd_new.price    = item.price;
		cmd_new.order_id = item.order_id & ID_MASK;
		cmd_new.in_range = 32'(item.price) < 32'(PRICE_LEVELS);
	end

	assign full     = (cnt_q == 2'd2) || hold;
	assign accept   = push && !full;
	assign take_ok  = take && (cnt_q != 2'd0);
	assign link.valid = cnt_q != 2'd0;
	assign link.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take_ok) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, take_ok};
		end
	end

endmodule

>>> rtl/obpls_back.sv
// back part: level count memory, order id memory and the add/remove sequencer
// depends on obpls_pkg

module obpls_back #(
	parameter int PRICE_LEVELS = 256,
	parameter int LEVEL_DEPTH  = 16,
	parameter int ID_BITS      = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  obpls_pkg::cmd_link_t  link,
	output logic                  take,
	output logic                  clearing,
	output logic                  res_valid,
	output obpls_pkg::result_t    res,
	input  logic                  res_pop
);
	import obpls_pkg::*;

	localparam int LEVELS   = (PRICE_LEVELS < 256) ? PRICE_LEVELS : 256;
	localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOT_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W    = $clog2(LEVEL_DEPTH + 1);
	localparam int SID_W    = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam int FILL_AW  = 1 + LVL_W;
	localparam int ENT_AW   = 1 + LVL_W + SLOT_W;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_FILL  = 5'b00100,
		S_SCAN  = 5'b01000,
		S_SHIFT = 5'b10000
	} state_t;

	logic [CNT_W-1:0] fill_mem [2**FILL_AW];
	logic [SID_W-1:0] ent_mem  [2**ENT_AW];

	state_t             state_q, state_d;
	logic [FILL_AW-1:0] clr_idx_q;
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   n_q;
	logic [SLOT_W-1:0]  idx_q, idx_d;
	logic               res_valid_q;
	result_t            res_q, res_d;
	logic               res_set;

	logic               fill_we;
	logic [FILL_AW-1:0] fill_waddr, fill_raddr;
	logic [CNT_W-1:0]   fill_wdata, fill_rd_q;
	logic               ent_we;
	logic [ENT_AW-1:0]  ent_waddr, ent_raddr;
	logic [SID_W-1:0]   ent_wdata, ent_rd_q;

	logic [FILL_AW-1:0] lvl_addr;
	logic [CNT_W-1:0]   n_cur, idx_next, idx_next2;
	logic               id_hit;

	assign lvl_addr   = {cmd_q.side, LVL_W'(cmd_q.price)};
	assign fill_raddr = {link.cmd.side, LVL_W'(link.cmd.price)};
	assign n_cur      = fill_rd_q;
	assign idx_next   = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_next2  = CNT_W'(idx_q) + CNT_W'(2);
	assign id_hit     = ent_rd_q == cmd_q.order_id[SID_W-1:0];

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		take       = 1'b0;
		res_set    = 1'b0;
		res_d      = res_q;
		fill_we    = 1'b0;
		fill_waddr = lvl_addr;
		fill_wdata = n_cur + CNT_W'(1);
		ent_we     = 1'b0;
		ent_waddr  = {lvl_addr, SLOT_W'(n_cur)};
		ent_wdata  = cmd_q.order_id[SID_W-1:0];
		ent_raddr  = {lvl_addr, idx_q + SLOT_W'(1)};
		unique case (state_q)
			S_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_idx_q;
				fill_wdata = '0;
				if (clr_idx_q == {FILL_AW{1'b1}}) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (link.valid && !res_valid_q) begin
					take = 1'b1;
					if (!link.cmd.in_range) begin
						res_set = 1'b1;
						res_d.status = (link.cmd.mode == MODE_REMOVE) ? ST_NOT_FOUND : ST_FULL;
						res_d.level_count = '0;
					end else begin
						state_d = S_FILL;
					end
				end
			end
			S_FILL: begin
				ent_raddr = {lvl_addr, {SLOT_W{1'b0}}};
				idx_d     = '0;
				if (cmd_q.mode == MODE_ADD) begin
					res_set = 1'b1;
					state_d = S_IDLE;
					if (n_cur == CNT_W'(LEVEL_DEPTH)) begin
						res_d.status      = ST_FULL;
						res_d.level_count = COUNT_W'(n_cur);
					end else begin
						ent_we            = 1'b1;
						fill_we           = 1'b1;
						res_d.status      = ST_DONE;
						res_d.level_count = COUNT_W'(n_cur + CNT_W'(1));
					end
				end else if (n_cur == '0) begin
					res_set           = 1'b1;
					res_d.status      = ST_NOT_FOUND;
					res_d.level_count = '0;
					state_d           = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (id_hit) begin
					if (idx_next == n_q) begin
						fill_we           = 1'b1;
						fill_wdata        = n_q - CNT_W'(1);
						res_set           = 1'b1;
						res_d.status      = ST_DONE;
						res_d.level_count = COUNT_W'(n_q - CNT_W'(1));
						state_d           = S_IDLE;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (idx_next == n_q) begin
					res_set           = 1'b1;
					res_d.status      = ST_NOT_FOUND;
					res_d.level_count = COUNT_W'(n_q);
					state_d           = S_IDLE;
				end else begin
					idx_d = idx_q + SLOT_W'(1);
				end
			end
			S_SHIFT: begin
				// move the next entry down over the current slot
				ent_we    = 1'b1;
				ent_waddr = {lvl_addr, idx_q};
				ent_wdata = ent_rd_q;
				ent_raddr = {lvl_addr, idx_q + SLOT_W'(2)};
				if (idx_next2 == n_q) begin
					fill_we           = 1'b1;
					fill_wdata        = n_q - CNT_W'(1);
					res_set           = 1'b1;
					res_d.status      = ST_DONE;
					res_d.level_count = COUNT_W'(n_q - CNT_W'(1));
					state_d           = S_IDLE;
				end else begin
					idx_d = idx_q + SLOT_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// level count memory
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		fill_rd_q <= fill_mem[fill_raddr];
	end

	// order id memory
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= link.cmd;
		end
		if (state_q == S_FILL) begin
			n_q <= n_cur;
		end
		if (res_set) begin
			res_q <= res_d;
		end
		idx_q <= idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_idx_q <= clr_idx_q + FILL_AW'(1);
			end
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign clearing  = state_q == S_CLEAR;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/order_book_price_level_store.sv
// top level of the order book price level store: front, command queue and back
// depends on obpls_pkg, obpls_front and obpls_back
//
// usage
// - input channel: an item (mode, side, price, order_id) is a transaction at a
//   rising edge with push high and full low; mode 0 adds the id at the tail of
//   the level list for that side and price, mode 1 removes the first equal id
// - result channel: one result per item, in item order; the oldest result is
//   on result while empty is low and is taken at an edge with pop high
// - status: done, not found on a remove, or full on an add to a full level;
//   a price outside the book answers full or not found with a count of zero
// - an out-of-book price is answered from idle; an add or a remove from an empty
//   level first reads the level count; a remove from a level of n entries then
//   scans up to the match, then shifts the rest down
// - one item at a time in the back; the next is taken the cycle after the result
//   is popped
// - the front queue holds two items, so the input keeps taking items while
//   the back works and while a result waits to be popped
// - a stalled result (pop low) holds the back in idle; the queue then fills
//   and full rises
// - reset: level counts are cleared by a pass over the count memory, one
//   entry a cycle, over its 2*min(PRICE_LEVELS,256) entries rounded up to a
//   power of two (512 by default); full stays high during that pass

module order_book_price_level_store #(
	parameter int PRICE_LEVELS = 256,
	parameter int LEVEL_DEPTH  = 16,
	parameter int ID_BITS      = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  obpls_pkg::item_t     item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output obpls_pkg::result_t   result
);
	import obpls_pkg::*;

	cmd_link_t link;
	logic      take;
	logic      clearing;
	logic      res_valid;

	// accepts and classifies items, queues them until the back is free
	obpls_front #(
		.PRICE_LEVELS (PRICE_LEVELS),
		.ID_BITS      (ID_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.hold   (clearing),
		.full   (full),
		.link   (link),
		.take   (take)
	);

	// carries out adds and removes, keeps the result register
	obpls_back #(
		.PRICE_LEVELS (PRICE_LEVELS),
		.LEVEL_DEPTH  (LEVEL_DEPTH),
		.ID_BITS      (ID_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.link      (link),
		.take      (take),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res       (result),
		.res_pop   (pop)
	);

	assign empty = !res_valid;

	// no transaction enters while level counts are being cleared
	a_full_while_clearing : assert property (
		@(posedge clk) disable iff (!arst_n) clearing |-> full
	) else $error("input open during count clearing");

	// results only exist after the clearing pass
	a_no_result_while_clearing : assert property (
		@(posedge clk) disable iff (!arst_n) res_valid |-> !clearing
	) else $error("result during count clearing");

	// a level never reports more orders than it can hold
	a_count_bound : assert property (
		@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(result.level_count) <= 32'(LEVEL_DEPTH))
	) else $error("level count above depth");

endmodule

>>> tb/testbench.sv
// testbench for order_book_price_level_store: directed and random add/remove traffic
// depends on obpls_pkg and the order_book_price_level_store rtl

module testbench;
	import obpls_pkg::*;

	// book geometry as the block is built by default
	localparam int BOOK_LEVELS   = 256;
	localparam int LEVEL_SLOTS   = 16;
	// random traffic: blocks of orders, the tail of the run without idling
	localparam int BLOCK_ORDERS  = 40;
	localparam int RANDOM_BLOCKS = 10;
	localparam int CALM_ORDERS   = 60;
	// settle time after the drain, with margin beyond the slowest remove
	localparam int SETTLE_CYCLES = 60;

	// shadow book: per side and price, the resting ids in arrival order
	class book_scoreboard;
		int unsigned     fill [2][BOOK_LEVELS];
		logic [ID_W-1:0] ids  [2][BOOK_LEVELS][LEVEL_SLOTS];
		result_t         replies_due [$];
		int unsigned     faults;

		function new();
			foreach (fill[s, p]) fill[s][p] = 0;
			faults = 0;
		endfunction

		// apply one order to the shadow book and return the reply it earns
		function result_t predict_reply(item_t it);
			result_t     r;
			int unsigned n;
			int          hit;
			int          i;
			r.status = ST_DONE;
			r.level_count = '0;
			// a price outside the book names no level
			if (int'(it.price) >= BOOK_LEVELS) begin
				r.status = (it.mode == MODE_ADD) ? ST_FULL : ST_NOT_FOUND;
				return r;
			end
			n = fill[it.side][it.price];
			if (it.mode == MODE_ADD) begin
				if (n >= LEVEL_SLOTS) begin
					// level full: refused, count unchanged
					r.status = ST_FULL;
				end else begin
					ids[it.side][it.price][n] = it.order_id;
					n++;
				end
			end else begin
				hit = -1;
				for (i = 0; i < int'(n); i++) begin
					if (ids[it.side][it.price][i] == it.order_id) begin
						hit = i;
						break;
					end
				end
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// close the gap so the rest keep their order
					for (i = hit; i + 1 < int'(n); i++)
						ids[it.side][it.price][i] = ids[it.side][it.price][i + 1];
					n--;
				end
			end
			fill[it.side][it.price] = n;
			r.level_count = COUNT_W'(n);
			return r;
		endfunction

		function void note_order(item_t it);
			replies_due = {replies_due, predict_reply(it)};
		endfunction

		function void check_reply(result_t got);
			result_t want;
			if (replies_due.size() == 0) begin
				$error("result with no pending transaction: status %0d level_count %0d",
					got.status, got.level_count);
				faults++;
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				faults++;
			end
			if (got.level_count !== want.level_count) begin
				$error("level_count expected %0d actual %0d", want.level_count, got.level_count);
				faults++;
			end
		endfunction

		// a random id resting at this level, or the fallback if the level is empty
		function logic [ID_W-1:0] resting_or(logic s, logic [PRICE_W-1:0] p,
				logic [ID_W-1:0] fallback);
			if (fill[s][p] == 0)
				return fallback;
			return ids[s][p][$urandom_range(0, fill[s][p] - 1)];
		endfunction
	endclass

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	item_t   item   = '0;
	logic    full;
	logic    pop    = 1'b0;
	logic    empty;
	result_t result;

	// set in the last part of the run: no idling on either side
	bit calm = 1'b0;

	book_scoreboard sb = new();

	order_book_price_level_store u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run, including the count clearing pass
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// monitor: values seen at the edge are the ones before the edge's updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_order(item);
			if (pop && !empty)
				sb.check_reply(result);
		end
	end

	// result side: random pop stalls in bursts, none once the run turns calm
	initial begin
		int unsigned stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (calm)
				stall = 0;
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 9) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// present one order and hold it until the transaction happens; push stays high
	task automatic send_order(logic op, logic bs, logic [PRICE_W-1:0] px, logic [ID_W-1:0] oid);
		item_t it;
		it.mode = op;
		it.side = bs;
		it.price = px;
		it.order_id = oid;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
	endtask

	task automatic sender_gap(int unsigned cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every pending reply has been popped
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.replies_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic              op;
		logic              bs;
		logic [PRICE_W-1:0] px;
		logic [ID_W-1:0]   oid;
		logic              focus_side;
		logic [PRICE_W-1:0] focus_price;
		int unsigned       add_pct;
		int unsigned       roll;
		bit                gaps_on;
		int                n;

		// hold reset, then release; the release lands on an edge, seen at the next one
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: fill the top buy level, with the extreme ids and a duplicate
		for (int k = 0; k < LEVEL_SLOTS; k++) begin
			if (k == 0)
				oid = 32'h0000_0000;
			else if (k == 1 || k == 7)
				oid = 32'hFFFF_FFFF;
			else
				oid = 32'h8000_0000 | k;
			send_order(MODE_ADD, 1'b1, 8'd255, oid);
		end
		// one more add to the full level is refused
		send_order(MODE_ADD, 1'b1, 8'd255, 32'h1234_5678);
		// duplicate id: only the first copy goes, later entries shift down
		send_order(MODE_REMOVE, 1'b1, 8'd255, 32'hFFFF_FFFF);
		// id that is not resting there
		send_order(MODE_REMOVE, 1'b1, 8'd255, 32'h7FFF_FFFF);
		// remove the tail entry
		send_order(MODE_REMOVE, 1'b1, 8'd255, 32'h8000_000F);
		// bottom sell level: remove from an empty level, then add and remove
		send_order(MODE_REMOVE, 1'b0, 8'd0, 32'h0000_0000);
		send_order(MODE_ADD, 1'b0, 8'd0, 32'hA5A5_5A5A);
		send_order(MODE_REMOVE, 1'b0, 8'd0, 32'hA5A5_5A5A);

		// hold the sender until the block has answered everything
		drain();

		// random: each block leans on one focus level so levels fill, empty and overflow
		n = 0;
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			focus_side = 1'($urandom_range(0, 1));
			focus_price = PRICE_W'($urandom_range(0, BOOK_LEVELS - 1));
			add_pct = $urandom_range(25, 85);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (blk == RANDOM_BLOCKS / 2)
				drain();
			for (int j = 0; j < BLOCK_ORDERS; j++) begin
				if (n >= RANDOM_BLOCKS * BLOCK_ORDERS - CALM_ORDERS)
					calm = 1'b1;
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					bs = focus_side;
					px = focus_price;
				end else if (roll < 90) begin
					// the two ends of the book stay busy too
					bs = 1'($urandom_range(0, 1));
					px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				end else begin
					bs = 1'($urandom_range(0, 1));
					px = PRICE_W'($urandom_range(0, BOOK_LEVELS - 1));
				end
				op = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_REMOVE;
				oid = $urandom();
				// removes mostly hit a resting id at head, middle or tail
				if (op == MODE_REMOVE && $urandom_range(0, 4) != 0)
					oid = sb.resting_or(bs, px, oid);
				// the odd add repeats a resting id
				if (op == MODE_ADD && $urandom_range(0, 9) == 0)
					oid = sb.resting_or(bs, px, oid);
				send_order(op, bs, px, oid);
				n++;
				if (!calm && gaps_on && $urandom_range(0, 4) == 0)
					sender_gap($urandom_range(1, 9));
			end
		end

		// wait out the last replies, then watch for stray ones
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
rtl/obpls_pkg.sv
rtl/obpls_front.sv
rtl/obpls_back.sv
rtl/order_book_price_level_store.sv
tb/testbench.sv
